// ===== rtl/bcpi_pkg.sv =====
// Shared types, constants and codes for the cascaded PI buck controller.
`default_nettype none

package bcpi_pkg;

    // Duty limits in Q0.16 and soft-start ramp increment in Q8.8 volts.
    localparam int DUTY_FLOOR = 0;
    localparam int DUTY_CEIL  = 62259;
    localparam int RAMP_STEP  = 1;

    // Duty limits in the Q0.24 working format of the inner loop.
    localparam int DUTY_FLOOR_Q24 = DUTY_FLOOR * 256;
    localparam int DUTY_CEIL_Q24  = DUTY_CEIL * 256;

    // Inner integrator bound, 0.25 in Q0.24.
    localparam int CINT_LIM = 1 << 22;

    // Feedforward ramp*4096/3 = ramp*1365 + floor(ramp/3); the last term
    // uses the reciprocal 43691 / 2^17, exact for every 16-bit ramp value.
    localparam logic [25:0] FF_INT   = 26'd1365;
    localparam logic [23:0] FF_RECIP = 24'd43691;

    // Mode codes.
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_SOFT  = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    // Fault flag bit positions.
    localparam int FLT_SENSOR  = 0;
    localparam int FLT_OVERCUR = 1;
    localparam int FLT_OVERVOL = 2;
    localparam int FLT_TIMEOUT = 3;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_TARGET   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_THRESHOLD     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_KP       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_KI       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_KP       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_KI       = 4'd7;

    // Register reset values.
    localparam logic [14:0] RST_VOLTAGE_TARGET = 15'd3072;
    localparam logic [14:0] RST_CURRENT_LIMIT  = 15'd2560;
    localparam logic [14:0] RST_OV_THRESHOLD   = 15'd3840;
    localparam logic [31:0] RST_HB_TIMEOUT     = 32'd10000;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VP,
        MUL_VI,
        MUL_FF,
        MUL_CP,
        MUL_CI
    } t_mul_sel;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic     capture;
        logic     check;
        t_mul_sel mul_sel;
        logic     outer_sum;
        logic     outer_int;
        logic     feedfwd;
        logic     inner_sum;
        logic     inner_int;
        logic     load_out;
    } t_dp_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic regulate;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/bcpi_ifs.sv =====
// Valid/ready channel interfaces for the tick input and the result output.
`default_nettype none

interface bcpi_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_voltage;
    logic signed [15:0] measured_current;
    logic               sensor_ok;
    logic               heartbeat;
    logic               enable;
    logic               clear_request;

    modport source (
        output valid, measured_voltage, measured_current, sensor_ok, heartbeat,
               enable, clear_request,
        input  ready
    );
    modport sink (
        input  valid, measured_voltage, measured_current, sensor_ok, heartbeat,
               enable, clear_request,
        output ready
    );
endinterface

interface bcpi_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_cycle;
    logic [1:0]  mode;
    logic [3:0]  fault_flags;
    logic [14:0] current_setpoint;

    modport source (
        output valid, duty_cycle, mode, fault_flags, current_setpoint,
        input  ready
    );
    modport sink (
        input  valid, duty_cycle, mode, fault_flags, current_setpoint,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/bcpi_ctrl.sv =====
// Sequencer that steps the datapath through one control tick.
`default_nettype none

module bcpi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output bcpi_pkg::t_dp_cmd     o_cmd,
    input  wire bcpi_pkg::t_dp_stat i_stat
);
    import bcpi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_VP,
        ST_VI,
        ST_VUPD,
        ST_CP,
        ST_CI,
        ST_CUPD,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.regulate ? ST_VP : ST_DONE;
            end
            ST_VP: begin
                o_cmd.mul_sel = MUL_VP;
                n_state       = ST_VI;
            end
            ST_VI: begin
                o_cmd.mul_sel   = MUL_VI;
                o_cmd.outer_sum = 1'b1;
                n_state         = ST_VUPD;
            end
            ST_VUPD: begin
                o_cmd.mul_sel   = MUL_FF;
                o_cmd.outer_int = 1'b1;
                n_state         = ST_CP;
            end
            ST_CP: begin
                o_cmd.mul_sel = MUL_CP;
                o_cmd.feedfwd = 1'b1;
                n_state       = ST_CI;
            end
            ST_CI: begin
                o_cmd.mul_sel   = MUL_CI;
                o_cmd.inner_sum = 1'b1;
                n_state         = ST_CUPD;
            end
            ST_CUPD: begin
                o_cmd.inner_int = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bcpi_dp.sv =====
// Datapath: registers, fault logic, shared multiplier and both PI loops.
`default_nettype none

module bcpi_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bcpi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bcpi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic signed [15:0]                 i_vout,
    input  wire logic signed [15:0]                 i_iout,
    input  wire logic                               i_sensor_ok,
    input  wire logic                               i_heartbeat,
    input  wire logic                               i_enable,
    input  wire logic                               i_clear,
    input  wire bcpi_pkg::t_dp_cmd                  i_cmd,
    output bcpi_pkg::t_dp_stat                      o_stat,
    output logic [15:0]                             o_duty,
    output logic [1:0]                              o_mode,
    output logic [3:0]                              o_flags,
    output logic [14:0]                             o_cref
);
    import bcpi_pkg::*;

    localparam logic signed [42:0] DMIN_S  = 43'(DUTY_FLOOR_Q24);
    localparam logic signed [42:0] DMAX_S  = 43'(DUTY_CEIL_Q24);
    localparam logic signed [42:0] CLIM_HI = 43'(CINT_LIM);
    localparam logic signed [42:0] CLIM_LO = -43'(CINT_LIM);
    localparam logic [23:0]        DMIN_U  = 24'(DUTY_FLOOR_Q24);
    localparam logic [23:0]        DMAX_U  = 24'(DUTY_CEIL_Q24);

    // Configuration registers.
    logic [14:0] r_vtgt, r_lim, r_ovt;
    logic [31:0] r_hbto;
    logic [15:0] r_kpv, r_kpi;
    logic [23:0] r_kiv, r_kii;

    // Captured tick word.
    logic signed [15:0] r_vout, r_iout;
    logic               r_sensor, r_beat, r_enable, r_clear;

    // Controller state.
    logic [1:0]         r_mode;
    logic [3:0]         r_flt;
    logic [31:0]        r_age;
    logic [15:0]        r_ramp;
    logic [14:0]        r_cref;
    logic [22:0]        r_vint;
    logic signed [23:0] r_cint;
    logic [15:0]        r_duty;

    // Intermediate results.
    logic signed [42:0] r_prod;
    logic [22:0]        r_vsum;
    logic [25:0]        r_ff;
    logic [23:0]        r_csum;

    // Output word.
    logic [15:0] r_o_duty;
    logic [1:0]  r_o_mode;
    logic [3:0]  r_o_flags;
    logic [14:0] r_o_cref;

    // Fault detection and clear qualification.
    logic [31:0]        w_age;
    logic               w_timeout;
    logic [3:0]         w_det, w_flt;
    logic signed [23:0] w_i100, w_l108;
    logic signed [19:0] w_i5;
    logic               w_clear_ok;

    assign w_age = r_beat ? 32'd0 :
                   ((r_age != '1) ? r_age + 32'd1 : r_age);
    assign w_timeout = (w_age > r_hbto);
    assign w_i100    = 24'(r_iout) * 24'sd100;
    assign w_l108    = $signed({9'd0, r_lim}) * 24'sd108;
    assign w_i5      = 20'(r_iout) * 20'sd5;

    always_comb begin
        w_det              = '0;
        w_det[FLT_SENSOR]  = !r_sensor;
        w_det[FLT_OVERCUR] = (w_i100 > w_l108);
        w_det[FLT_OVERVOL] = (r_vout > $signed({1'b0, r_ovt}));
        w_det[FLT_TIMEOUT] = w_timeout;
    end

    assign w_flt      = r_flt | w_det;
    assign w_clear_ok = r_clear && r_sensor && (w_i5 < $signed({5'd0, r_lim})) &&
                        ($signed({r_vout, 1'b0}) < $signed({2'b00, r_vtgt})) &&
                        !w_timeout;
    assign o_stat.regulate = (w_flt == 4'd0) && r_enable;

    // Soft-start ramp and mode progression.
    logic [1:0]  w_mode0, w_mode_n;
    logic [16:0] w_rinc;
    logic [15:0] w_ramp_n;

    always_comb begin
        w_mode0  = (r_mode == MODE_OFF) ? MODE_SOFT : r_mode;
        w_mode_n = w_mode0;
        w_rinc   = {1'b0, r_ramp} + 17'(RAMP_STEP);
        w_ramp_n = {1'b0, r_vtgt};
        if (w_mode0 == MODE_SOFT) begin
            if (w_rinc >= {2'b00, r_vtgt}) begin
                w_mode_n = MODE_RUN;
            end else begin
                w_ramp_n = w_rinc[15:0];
            end
        end
    end

    // Loop errors.
    logic signed [17:0] w_verr, w_cerr;

    assign w_verr = $signed({2'b00, r_ramp}) - 18'(r_vout);
    assign w_cerr = $signed({3'b000, r_cref}) - 18'(r_iout);

    // Shared multiplier, 25 by 18 bits signed.
    logic [23:0]        w_ma;
    logic signed [17:0] w_mb;
    logic signed [42:0] w_prod;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_VP: begin
                w_ma = {8'd0, r_kpv};
                w_mb = w_verr;
            end
            MUL_VI: begin
                w_ma = r_kiv;
                w_mb = w_verr;
            end
            MUL_FF: begin
                w_ma = FF_RECIP;
                w_mb = $signed({2'b00, r_ramp});
            end
            MUL_CP: begin
                w_ma = {8'd0, r_kpi};
                w_mb = w_cerr;
            end
            MUL_CI: begin
                w_ma = r_kii;
                w_mb = w_cerr;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = $signed({19'd0, w_ma}) * 43'(w_mb);

    // Outer loop sum and integrator, Q8.16 amps.
    logic [22:0]        w_lim16;
    logic signed [42:0] w_lim16_s, w_vsum_raw, w_vi_raw;
    logic [22:0]        w_vsum_c, w_vi_c;
    logic               w_vcond;

    assign w_lim16    = {r_lim, 8'd0};
    assign w_lim16_s  = $signed({20'd0, w_lim16});
    assign w_vsum_raw = (r_prod >>> 4) + $signed({20'd0, r_vint});
    assign w_vi_raw   = (r_prod >>> 16) + $signed({20'd0, r_vint});

    always_comb begin
        if (w_vsum_raw < 43'sd0) begin
            w_vsum_c = '0;
        end else if (w_vsum_raw > w_lim16_s) begin
            w_vsum_c = w_lim16;
        end else begin
            w_vsum_c = w_vsum_raw[22:0];
        end
        if (w_vi_raw < 43'sd0) begin
            w_vi_c = '0;
        end else if (w_vi_raw > w_lim16_s) begin
            w_vi_c = w_lim16;
        end else begin
            w_vi_c = w_vi_raw[22:0];
        end
    end

    assign w_vcond = ((r_vsum != 23'd0) && (r_vsum < w_lim16)) ||
                     ((r_vsum >= w_lim16) && w_verr[17]) ||
                     ((r_vsum == 23'd0) && !w_verr[17] && (w_verr != 18'sd0));

    // Feedforward ramp*4096/3 in Q0.24 duty.
    logic [25:0] w_ff;

    assign w_ff = (26'(r_ramp) * FF_INT) + r_prod[42:17];

    // Inner loop sum and integrator, Q0.24 duty.
    logic signed [42:0] w_csum_raw, w_ci_raw;
    logic [23:0]        w_csum_c;
    logic signed [23:0] w_ci_c;
    logic               w_ccond;

    assign w_csum_raw = $signed({17'd0, r_ff}) + (r_prod <<< 4) + 43'(r_cint);
    assign w_ci_raw   = 43'(r_cint) + (r_prod >>> 8);

    always_comb begin
        if (w_csum_raw < DMIN_S) begin
            w_csum_c = DMIN_U;
        end else if (w_csum_raw > DMAX_S) begin
            w_csum_c = DMAX_U;
        end else begin
            w_csum_c = w_csum_raw[23:0];
        end
        if (w_ci_raw < CLIM_LO) begin
            w_ci_c = CLIM_LO[23:0];
        end else if (w_ci_raw > CLIM_HI) begin
            w_ci_c = CLIM_HI[23:0];
        end else begin
            w_ci_c = w_ci_raw[23:0];
        end
    end

    assign w_ccond = ((r_csum > DMIN_U) && (r_csum < DMAX_U)) ||
                     ((r_csum >= DMAX_U) && w_cerr[17]) ||
                     ((r_csum <= DMIN_U) && !w_cerr[17] && (w_cerr != 18'sd0));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtgt <= RST_VOLTAGE_TARGET;
            r_lim  <= RST_CURRENT_LIMIT;
            r_ovt  <= RST_OV_THRESHOLD;
            r_hbto <= RST_HB_TIMEOUT;
            r_kpv  <= '0;
            r_kiv  <= '0;
            r_kpi  <= '0;
            r_kii  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOLTAGE_TARGET: r_vtgt <= i_cfg_data[14:0];
                CFG_CURRENT_LIMIT:  r_lim  <= i_cfg_data[14:0];
                CFG_OV_THRESHOLD:   r_ovt  <= i_cfg_data[14:0];
                CFG_HB_TIMEOUT:     r_hbto <= i_cfg_data;
                CFG_VOLTAGE_KP:     r_kpv  <= i_cfg_data[15:0];
                CFG_VOLTAGE_KI:     r_kiv  <= i_cfg_data[23:0];
                CFG_CURRENT_KP:     r_kpi  <= i_cfg_data[15:0];
                CFG_CURRENT_KI:     r_kii  <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // Captured tick word, product and intermediate sums.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vout   <= i_vout;
            r_iout   <= i_iout;
            r_sensor <= i_sensor_ok;
            r_beat   <= i_heartbeat;
            r_enable <= i_enable;
            r_clear  <= i_clear;
        end
        r_prod <= w_prod;
        if (i_cmd.outer_sum) begin
            r_vsum <= w_vsum_c;
        end
        if (i_cmd.feedfwd) begin
            r_ff <= w_ff;
        end
        if (i_cmd.inner_sum) begin
            r_csum <= w_csum_c;
        end
        if (i_cmd.load_out) begin
            r_o_duty  <= r_duty;
            r_o_mode  <= r_mode;
            r_o_flags <= r_flt;
            r_o_cref  <= r_cref;
        end
    end

    // Controller state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_flt  <= '0;
            r_age  <= '0;
            r_ramp <= '0;
            r_cref <= '0;
            r_vint <= '0;
            r_cint <= '0;
            r_duty <= '0;
        end else begin
            if (i_cmd.check) begin
                r_age <= w_age;
                r_flt <= w_flt;
                if (w_flt != 4'd0) begin
                    r_mode <= MODE_FAULT;
                    r_duty <= '0;
                    r_cref <= '0;
                    r_cint <= '0;
                    if (w_clear_ok) begin
                        r_flt  <= '0;
                        r_mode <= MODE_OFF;
                        r_ramp <= '0;
                        r_vint <= '0;
                    end
                end else if (!r_enable) begin
                    r_mode <= MODE_OFF;
                    r_ramp <= '0;
                    r_cref <= '0;
                    r_vint <= '0;
                    r_cint <= '0;
                    r_duty <= '0;
                end else begin
                    r_mode <= w_mode_n;
                    r_ramp <= w_ramp_n;
                end
            end
            if (i_cmd.outer_sum) begin
                r_cref <= w_vsum_c[22:8];
            end
            if (i_cmd.outer_int && w_vcond) begin
                r_vint <= w_vi_c;
            end
            if (i_cmd.inner_sum) begin
                r_duty <= w_csum_c[23:8];
            end
            if (i_cmd.inner_int && w_ccond) begin
                r_cint <= w_ci_c;
            end
        end
    end

    assign o_duty  = r_o_duty;
    assign o_mode  = r_o_mode;
    assign o_flags = r_o_flags;
    assign o_cref  = r_o_cref;

endmodule

`default_nettype wire

// ===== rtl/buck_cascaded_pi_controller_unit.sv =====
// Top level of the cascaded voltage/current PI controller for a buck converter.
// Each input word is one control tick and yields exactly one result word. A tick
// that regulates (enabled, no fault latched) steps through the check, outer Kp,
// outer Ki, outer update, inner Kp, inner Ki, inner update and done states, because
// the outer and inner loops share one 25x18-bit multiplier that is used five times
// in turn (outer Kp and Ki, feedforward divide by three, inner Kp and Ki); an off or
// faulted tick goes from the check state straight to done. One tick is in work at
// a time; a result waits in an output register, so the next tick can be taken while
// it does. Registers are to be written by the user through the write port only
// while no tick is in flight; the block itself does not enforce this.
`default_nettype none

module buck_cascaded_pi_controller_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bcpi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bcpi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bcpi_in_if.sink                                 i_in_ch,
    bcpi_out_if.source                              o_out_ch
);
    import bcpi_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Tick sequencer.
    bcpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Arithmetic and state.
    bcpi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_vout      (i_in_ch.measured_voltage),
        .i_iout      (i_in_ch.measured_current),
        .i_sensor_ok (i_in_ch.sensor_ok),
        .i_heartbeat (i_in_ch.heartbeat),
        .i_enable    (i_in_ch.enable),
        .i_clear     (i_in_ch.clear_request),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_duty      (o_out_ch.duty_cycle),
        .o_mode      (o_out_ch.mode),
        .o_flags     (o_out_ch.fault_flags),
        .o_cref      (o_out_ch.current_setpoint)
    );

endmodule

`default_nettype wire

// ===== rtl/bcpi_checker.sv =====
// Port-level checks on the result words of the controller, bound to the top level.
`default_nettype none

module bcpi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_duty,
    input wire logic [1:0]  i_mode,
    input wire logic [3:0]  i_flags,
    input wire logic [14:0] i_cref
);
    import bcpi_pkg::*;

    // A latched fault forces the duty and the current reference to zero.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mode == MODE_FAULT) |-> (i_duty == 16'd0) && (i_cref == 15'd0))
        else $error("fault word with nonzero drive");

    // Off mode drives nothing.
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mode == MODE_OFF) |-> (i_duty == 16'd0) && (i_cref == 15'd0))
        else $error("off word with nonzero drive");

    // Flags are shown exactly when the fault mode is.
    a_flags_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_flags != 4'd0) == (i_mode == MODE_FAULT)))
        else $error("fault flags disagree with mode");

    // Duty never exceeds its ceiling.
    a_duty_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_duty <= 16'(DUTY_CEIL)))
        else $error("duty above ceiling");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty) &&
        $stable(i_mode) && $stable(i_flags) && $stable(i_cref))
        else $error("stalled word changed");

endmodule

bind buck_cascaded_pi_controller_unit bcpi_checker u_bcpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_duty      (o_out_ch.duty_cycle),
    .i_mode      (o_out_ch.mode),
    .i_flags     (o_out_ch.fault_flags),
    .i_cref      (o_out_ch.current_setpoint)
);

`default_nettype wire

// ===== tb/tb_buck_cascaded_pi_controller_unit.sv =====
// Self-checking testbench for the cascaded PI buck controller unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_buck_cascaded_pi_controller_unit;
    import bcpi_pkg::*;

    // One control tick as offered to the block.
    typedef struct packed {
        logic signed [15:0] vout;
        logic signed [15:0] iout;
        logic               sensor_ok;
        logic               heartbeat;
        logic               enable;
        logic               clear_request;
    } t_tick;

    // One result word of the block.
    typedef struct packed {
        logic [15:0] duty;
        logic [1:0]  mode;
        logic [3:0]  faults;
        logic [14:0] isetp;
    } t_ctrl_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bcpi_in_if  tick_ch ();
    bcpi_out_if res_ch ();

    buck_cascaded_pi_controller_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (tick_ch),
        .o_out_ch   (res_ch)
    );

    // Clock with a 20 ns period.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the control state.
    logic [14:0] p_vtarget, p_ilimit, p_ovth;
    logic [31:0] p_hbto;
    logic [15:0] p_vkp, p_ckp;
    logic [23:0] p_vki, p_cki;
    logic [1:0]  p_mode;
    logic [3:0]  p_faults;
    logic [31:0] p_age;
    longint      p_ramp, p_iref, p_vint, p_cint, p_duty;

    t_tick     tick_queue[$];
    t_ctrl_out duty_queue[$];
    int  send_idle_pct, recv_idle_pct;
    int  hold_cycles;
    bit  failed;

    function automatic longint floor_sh(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the controller model by one tick and queue the expected word.
    task automatic predict_tick(input t_tick t);
        longint vo, io, lim, vref, verr, vsum, lim16, cerr, csum, dmax;
        logic [3:0] det;
        t_ctrl_out r;
        vo = t.vout; io = t.iout;
        lim = p_ilimit; vref = p_vtarget;
        det = '0;
        if (t.heartbeat) p_age = '0;
        else if (p_age != 32'hFFFF_FFFF) p_age = p_age + 32'd1;
        if (!t.sensor_ok) det[FLT_SENSOR] = 1'b1;
        if (io * 100 > lim * 108) det[FLT_OVERCUR] = 1'b1;
        if (vo > longint'(p_ovth)) det[FLT_OVERVOL] = 1'b1;
        if (p_age > p_hbto) det[FLT_TIMEOUT] = 1'b1;
        p_faults = p_faults | det;
        if (p_faults != 0) begin
            p_mode = MODE_FAULT;
            p_duty = 0; p_iref = 0; p_cint = 0;
            if (t.clear_request && t.sensor_ok && io * 5 < lim && vo * 2 < vref
                    && p_age <= p_hbto) begin
                p_faults = '0;
                p_mode = MODE_OFF;
                p_ramp = 0; p_vint = 0;
            end
        end else if (!t.enable) begin
            p_mode = MODE_OFF;
            p_ramp = 0; p_iref = 0; p_vint = 0; p_cint = 0; p_duty = 0;
        end else begin
            if (p_mode == MODE_OFF) p_mode = MODE_SOFT;
            if (p_mode == MODE_SOFT) begin
                p_ramp = p_ramp + RAMP_STEP;
                if (p_ramp >= vref) begin
                    p_ramp = vref;
                    p_mode = MODE_RUN;
                end
            end else begin
                p_ramp = vref;
            end
            // Outer voltage loop in Q8.16 amps.
            lim16 = lim * 256;
            verr = p_ramp - vo;
            vsum = clampl(floor_sh(longint'(p_vkp) * verr, 4) + p_vint, 0, lim16);
            p_iref = vsum >>> 8;
            if ((vsum > 0 && vsum < lim16) || (vsum >= lim16 && verr < 0) ||
                    (vsum <= 0 && verr > 0))
                p_vint = clampl(p_vint + floor_sh(longint'(p_vki) * verr, 16), 0, lim16);
            // Inner current loop in Q0.24 duty.
            dmax = longint'(DUTY_CEIL_Q24);
            cerr = p_iref - io;
            csum = (p_ramp * 4096) / 3 + longint'(p_ckp) * cerr * 16 + p_cint;
            csum = clampl(csum, DUTY_FLOOR_Q24, dmax);
            p_duty = csum >>> 8;
            if ((csum > DUTY_FLOOR_Q24 && csum < dmax) || (csum >= dmax && cerr < 0) ||
                    (csum <= DUTY_FLOOR_Q24 && cerr > 0))
                p_cint = clampl(p_cint + floor_sh(longint'(p_cki) * cerr, 8),
                                -CINT_LIM, CINT_LIM);
        end
        r.duty   = p_duty[15:0];
        r.mode   = p_mode;
        r.faults = p_faults;
        r.isetp  = p_iref[14:0];
        duty_queue.push_back(r);
    endtask

    // Acceptance is recorded at the rising edge; the falling edge reloads.
    bit in_fire;
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && tick_ch.valid && tick_ch.ready;
        if (i_rst_n && tick_ch.valid && tick_ch.ready)
            predict_tick({tick_ch.measured_voltage, tick_ch.measured_current,
                          tick_ch.sensor_ok, tick_ch.heartbeat, tick_ch.enable,
                          tick_ch.clear_request});
    end

    // Driver: offer the oldest pending word, idling at random.
    always @(negedge i_clk) begin
        t_tick t;
        if (i_rst_n && (!tick_ch.valid || in_fire)) begin
            if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t = tick_queue.pop_front();
                tick_ch.valid            <= 1'b1;
                tick_ch.measured_voltage <= t.vout;
                tick_ch.measured_current <= t.iout;
                tick_ch.sensor_ok        <= t.sensor_ok;
                tick_ch.heartbeat        <= t.heartbeat;
                tick_ch.enable           <= t.enable;
                tick_ch.clear_request    <= t.clear_request;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready: long hold-off when requested, else random stalls.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_ctrl_out e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (duty_queue.size() == 0) begin
                $error("unexpected result word");
                failed = 1'b1;
            end else begin
                e = duty_queue.pop_front();
                if (res_ch.duty_cycle !== e.duty) begin
                    $error("duty_cycle expected %0d got %0d", e.duty, res_ch.duty_cycle);
                    failed = 1'b1;
                end
                if (res_ch.mode !== e.mode) begin
                    $error("mode expected %0d got %0d", e.mode, res_ch.mode);
                    failed = 1'b1;
                end
                if (res_ch.fault_flags !== e.faults) begin
                    $error("fault_flags expected %0h got %0h", e.faults,
                           res_ch.fault_flags);
                    failed = 1'b1;
                end
                if (res_ch.current_setpoint !== e.isetp) begin
                    $error("current_setpoint expected %0d got %0d", e.isetp,
                           res_ch.current_setpoint);
                    failed = 1'b1;
                end
            end
        end
    end

    // Write one register in the block and in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_VOLTAGE_TARGET: p_vtarget = val[14:0];
            CFG_CURRENT_LIMIT:  p_ilimit  = val[14:0];
            CFG_OV_THRESHOLD:   p_ovth    = val[14:0];
            CFG_HB_TIMEOUT:     p_hbto    = val;
            CFG_VOLTAGE_KP:     p_vkp     = val[15:0];
            CFG_VOLTAGE_KI:     p_vki     = val[23:0];
            CFG_CURRENT_KP:     p_ckp     = val[15:0];
            CFG_CURRENT_KI:     p_cki     = val[23:0];
            default: ;
        endcase
    endtask

    // Wait until every queued word is accepted and every result has arrived.
    task automatic drain();
        while (tick_queue.size() > 0 || tick_ch.valid || duty_queue.size() > 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic t_tick rand_tick(input int vt);
        t_tick t;
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            // Mostly healthy ticks close to the setpoint.
            t.vout = 16'(vt + $signed($urandom_range(600)) - 300);
            t.iout = 16'($signed($urandom_range(1500)) - 300);
            t.sensor_ok = ($urandom_range(99) < 98);
            t.heartbeat = ($urandom_range(99) < 90);
            t.enable = ($urandom_range(99) < 95);
            t.clear_request = ($urandom_range(99) < 20);
        end else if (r < 85) begin
            // Safe ticks that let a latched fault be cleared.
            t.vout = 16'($signed($urandom_range(600)) - 300);
            t.iout = 16'($signed($urandom_range(200)) - 100);
            t.sensor_ok = 1'b1;
            t.heartbeat = 1'b1;
            t.enable = 1'($urandom_range(1));
            t.clear_request = 1'b1;
        end else begin
            t = t_tick'({$urandom, 4'($urandom)});
            t.vout = 16'($urandom);
        end
        return t;
    endfunction

    task automatic random_phase(input int n, input int vt);
        repeat (n) tick_queue.push_back(rand_tick(vt));
    endtask

    // Stimulus, register phases and end of run.
    initial begin
        t_tick t;
        failed = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        tick_ch.valid = 1'b0; tick_ch.measured_voltage = '0;
        tick_ch.measured_current = '0; tick_ch.sensor_ok = 1'b0;
        tick_ch.heartbeat = 1'b0; tick_ch.enable = 1'b0; tick_ch.clear_request = 1'b0;
        res_ch.ready = 1'b0;
        hold_cycles = 0; in_fire = 1'b0;
        send_idle_pct = 34; recv_idle_pct = 62;
        p_vtarget = RST_VOLTAGE_TARGET; p_ilimit = RST_CURRENT_LIMIT;
        p_ovth = RST_OV_THRESHOLD; p_hbto = RST_HB_TIMEOUT;
        p_vkp = '0; p_vki = '0; p_ckp = '0; p_cki = '0;
        p_mode = MODE_OFF; p_faults = '0; p_age = '0;
        p_ramp = 0; p_iref = 0; p_vint = 0; p_cint = 0; p_duty = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a short target so the ramp reaches run, plus each fault.
        write_reg(CFG_VOLTAGE_TARGET, 32'd4);
        write_reg(CFG_VOLTAGE_KP, 32'd4096);
        write_reg(CFG_VOLTAGE_KI, 32'd65536);
        write_reg(CFG_CURRENT_KP, 32'd4096);
        write_reg(CFG_CURRENT_KI, 32'd256);
        write_reg(CFG_HB_TIMEOUT, 32'd3);
        t = '{vout: 0, iout: 0, sensor_ok: 1, heartbeat: 1, enable: 1, clear_request: 0};
        repeat (6) tick_queue.push_back(t);
        t.vout = 16'sh7FFF; tick_queue.push_back(t);       // overvoltage
        t.vout = 0; t.clear_request = 1; tick_queue.push_back(t);
        t.iout = 16'sh7FFF; t.clear_request = 0; tick_queue.push_back(t); // overcurrent
        t.iout = 16'sh8000; t.clear_request = 1; tick_queue.push_back(t);
        t.iout = 0; tick_queue.push_back(t);
        t.sensor_ok = 0; t.clear_request = 0; tick_queue.push_back(t);  // sensor
        t.sensor_ok = 1; t.clear_request = 1; tick_queue.push_back(t);
        t.vout = 16'sh8000; t.clear_request = 0; tick_queue.push_back(t);
        t.heartbeat = 0; repeat (5) tick_queue.push_back(t);            // timeout
        t.heartbeat = 1; t.clear_request = 1; t.vout = 0; tick_queue.push_back(t);
        t.enable = 0; t.clear_request = 0; tick_queue.push_back(t);
        drain();

        // Random with realistic gains.
        write_reg(CFG_VOLTAGE_TARGET, 32'd40);
        write_reg(CFG_CURRENT_LIMIT, 32'd2560);
        write_reg(CFG_HB_TIMEOUT, 32'd20);
        write_reg(CFG_VOLTAGE_KP, $urandom_range(8000));
        write_reg(CFG_VOLTAGE_KI, $urandom_range(2000000));
        write_reg(CFG_CURRENT_KP, $urandom_range(8000));
        write_reg(CFG_CURRENT_KI, $urandom_range(2000000));
        random_phase(400, 40);
        drain();

        // Roles of idling swapped, with a long receiver hold-off.
        send_idle_pct = 62; recv_idle_pct = 34;
        write_reg(CFG_VOLTAGE_TARGET, 32'd0);
        write_reg(CFG_CURRENT_LIMIT, 32'd0);
        write_reg(CFG_OV_THRESHOLD, 32'd0);
        write_reg(CFG_HB_TIMEOUT, 32'hFFFF_FFFF);
        random_phase(200, 0);
        hold_cycles = 300;
        drain();

        // Extreme gains and thresholds.
        write_reg(CFG_VOLTAGE_TARGET, 32'h7FFF);
        write_reg(CFG_CURRENT_LIMIT, 32'h7FFF);
        write_reg(CFG_OV_THRESHOLD, 32'h7FFF);
        write_reg(CFG_HB_TIMEOUT, 32'hFFFF_FFFE);
        write_reg(CFG_VOLTAGE_KP, 32'hFFFF);
        write_reg(CFG_VOLTAGE_KI, 32'hFF_FFFF);
        write_reg(CFG_CURRENT_KP, 32'hFFFF);
        write_reg(CFG_CURRENT_KI, 32'hFF_FFFF);
        write_reg(4'd9, 32'h1234);
        random_phase(400, 16000);
        drain();

        // No idling at all, moderate settings.
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_VOLTAGE_TARGET, 32'd30);
        write_reg(CFG_CURRENT_LIMIT, 32'd1200);
        write_reg(CFG_OV_THRESHOLD, 32'd3840);
        write_reg(CFG_HB_TIMEOUT, 32'd10);
        write_reg(CFG_VOLTAGE_KP, $urandom);
        write_reg(CFG_VOLTAGE_KI, $urandom);
        write_reg(CFG_CURRENT_KP, $urandom);
        write_reg(CFG_CURRENT_KI, $urandom);
        random_phase(630, 30);
        drain();

        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run-time limit.
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
